// ===== hdl/permutation_pack_unpack_addresser_assert.svh =====
// Assertion macros for the permutation addresser.
// Included by the top level; no other dependencies.
`ifndef PERMUTATION_PACK_UNPACK_ADDRESSER_ASSERT_SVH
`define PERMUTATION_PACK_UNPACK_ADDRESSER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define PPUA_ASSERT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("ppua assertion failed");
// Next-cycle implication, disabled during reset.
`define PPUA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("ppua assertion failed");
`else
`define PPUA_ASSERT(label, clk, rstn, ante, cons)
`define PPUA_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// ===== hdl/ppua_pkg.sv =====
// Shared types and constants for the permutation addresser.
// No dependencies; imported by every module of the block.
package ppua_pkg;

    localparam int PPUA_MAX_ROWS_DEF = 1024;

    // Field and register widths.
    localparam int CANON_W     = 16;
    localparam int CMP_W       = 17;
    localparam int MODE_W      = 2;
    localparam int COUNT_W     = 11;
    localparam int RWIDTH_W    = 13;
    localparam int OFFS_W      = 22;
    localparam int WIDTH_LIMIT = 4096;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;

    // Transform modes; the unused code behaves as preserve.
    localparam logic [MODE_W-1:0] MODE_PRESERVE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_PACK     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_UNPACK   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 2'd2;

    typedef enum logic [1:0] {
        ST_COPY    = 2'd0,
        ST_INVALID = 2'd1,
        ST_SKIPPED = 2'd2
    } status_t;

    // Mark bitmap update issued by the processing stage.
    typedef struct packed {
        logic apply;
        logic first;
        logic set_mark;
        logic clear_all;
    } mark_upd_t;

endpackage

// ===== hdl/ppua_mark_store.sv =====
// Seen-mark bitmap: a row-organized memory with per-row valid bits and write forwarding.
// Depends on ppua_pkg.
module ppua_mark_store
    import ppua_pkg::*;
#(
    parameter int MAX_ROWS = PPUA_MAX_ROWS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               rd_en,
    input  logic [CANON_W-1:0] rd_index,
    input  logic [CANON_W-1:0] cur_index,
    input  mark_upd_t          upd,
    output logic               mark_seen
);

    localparam int ROW_BITS = (MAX_ROWS > 8192) ? 256 : 32;
    localparam int COL_W    = $clog2(ROW_BITS);
    localparam int NUM_ROWS = (MAX_ROWS + ROW_BITS - 1) / ROW_BITS;
    localparam int RIDX_W   = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int DEPTH    = 2 ** RIDX_W;

    logic [ROW_BITS-1:0] mem [DEPTH];
    logic [ROW_BITS-1:0] rdata_reg;
    logic [ROW_BITS-1:0] fwd_data_reg;
    logic                fwd_hit_reg;
    logic [DEPTH-1:0]    row_valid_reg;
    logic [DEPTH-1:0]    row_valid_next;

    logic [RIDX_W-1:0]   rd_row;
    logic [RIDX_W-1:0]   cur_row;
    logic [COL_W-1:0]    cur_col;
    logic [ROW_BITS-1:0] eff_row;
    logic [ROW_BITS-1:0] base_row;
    logic [ROW_BITS-1:0] wdata;
    logic                we;

    assign rd_row  = rd_index[COL_W +: RIDX_W];
    assign cur_row = cur_index[COL_W +: RIDX_W];
    assign cur_col = cur_index[COL_W-1:0];

    // Current row contents: forwarded write data wins over the stale read; invalid rows read zero.
    assign eff_row   = row_valid_reg[cur_row] ? (fwd_hit_reg ? fwd_data_reg : rdata_reg) : '0;
    assign base_row  = upd.first ? '0 : eff_row;
    assign mark_seen = base_row[cur_col];
    assign wdata     = base_row | (ROW_BITS'(1) << cur_col);
    assign we        = upd.apply && upd.set_mark;

    // Row valid bits: a new run or a finished run drops every row at once.
    always_comb begin
        row_valid_next = row_valid_reg;
        if (upd.apply) begin
            if (upd.first) begin
                row_valid_next = '0;
            end
            if (upd.set_mark) begin
                row_valid_next[cur_row] = 1'b1;
            end
            if (upd.clear_all) begin
                row_valid_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_valid_reg <= '0;
            fwd_hit_reg   <= 1'b0;
        end else begin
            row_valid_reg <= row_valid_next;
            if (rd_en) begin
                fwd_hit_reg <= we && (cur_row == rd_row);
            end
        end
    end

    // Memory port: read for the incoming transaction, write for the one leaving the stage.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[cur_row] <= wdata;
        end
        if (rd_en) begin
            rdata_reg    <= mem[rd_row];
            fwd_data_reg <= wdata;
        end
    end

endmodule

// ===== hdl/ppua_offset_unit.sv =====
// Offset multipliers and the result register of the permutation addresser.
// Depends on ppua_pkg.
module ppua_offset_unit
    import ppua_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  logic [CANON_W-1:0]  src_row,
    input  logic [CANON_W-1:0]  dst_row,
    input  logic [RWIDTH_W-1:0] row_width,
    input  status_t             status,
    input  logic                last,
    input  logic                m_ready,
    output logic                m_valid,
    output logic [OFFS_W-1:0]   m_source_offset,
    output logic [OFFS_W-1:0]   m_destination_offset,
    output logic [1:0]          m_status,
    output logic                m_last
);

    logic [CANON_W+RWIDTH_W-1:0] src_prod;
    logic [CANON_W+RWIDTH_W-1:0] dst_prod;
    logic                        m_valid_reg;
    logic [OFFS_W-1:0]           src_off_reg;
    logic [OFFS_W-1:0]           dst_off_reg;
    status_t                     status_reg;
    logic                        last_reg;

    // Row index times row width, kept to the offset width.
    assign src_prod = src_row * row_width;
    assign dst_prod = dst_row * row_width;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            src_off_reg <= src_prod[OFFS_W-1:0];
            dst_off_reg <= dst_prod[OFFS_W-1:0];
            status_reg  <= status;
            last_reg    <= last;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_source_offset      = src_off_reg;
    assign m_destination_offset = dst_off_reg;
    assign m_status             = status_reg;
    assign m_last               = last_reg;

endmodule

// ===== hdl/permutation_pack_unpack_addresser.sv =====
// An accepted transaction waits in the input register; its result is then held in the offset unit's result register.
// Throughput: one transaction per cycle while the output is empty or m_ready takes the result; the mark check
// is one read-modify-write of the bitmap memory, with the write forwarded to the next transaction's read.
// Reset (aresetn, synchronous, active low) restores mode 0, count 1, width 1, clears the
// row counter and failure flag, and drops every bitmap row valid bit at once (no sweep).
module permutation_pack_unpack_addresser
    import ppua_pkg::*;
#(
    parameter int MAX_ROWS = PPUA_MAX_ROWS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [CANON_W-1:0]    s_canonical_index,
    input  logic                  s_first_of_run,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [OFFS_W-1:0]     m_source_offset,
    output logic [OFFS_W-1:0]     m_destination_offset,
    output logic [1:0]            m_status,
    output logic                  m_last
);

    localparam int PR_W = $clog2(MAX_ROWS);

    logic [MODE_W-1:0]   mode_reg;
    logic [COUNT_W-1:0]  count_reg;
    logic [RWIDTH_W-1:0] width_reg;

    logic                in_valid_reg;
    logic [CANON_W-1:0]  canon_reg;
    logic                first_reg;
    logic [PR_W-1:0]     physical_row_reg;
    logic [PR_W-1:0]     physical_row_next;
    logic                run_failed_reg;
    logic                run_failed_next;

    logic                accept;
    logic                adv;
    logic [PR_W-1:0]     pr_eff;
    logic                failed_eff;
    logic [CMP_W-1:0]    count_ext;
    logic [CMP_W-1:0]    count_cl;
    logic [CMP_W-1:0]    pr_plus;
    logic [RWIDTH_W-1:0] width_cl;
    logic                permute;
    logic                mark_seen;
    logic                canon_bad;
    logic                done;
    status_t             status;
    logic                last;
    logic [CANON_W-1:0]  src_row;
    logic [CANON_W-1:0]  dst_row;
    logic                set_mark;
    logic                fail_set;
    logic                done_clear;
    mark_upd_t           mark_upd;

    // Configuration writes are taken in any cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_PRESERVE;
            count_reg <= COUNT_W'(1);
            width_reg <= RWIDTH_W'(1);
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MODE:  mode_reg  <= cfg_data[MODE_W-1:0];
                CFG_COUNT: count_reg <= cfg_data[COUNT_W-1:0];
                CFG_WIDTH: width_reg <= cfg_data[RWIDTH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register; it refills in the same cycle its transaction moves on.
    assign adv     = in_valid_reg && (!m_valid || m_ready);
    assign s_ready = !in_valid_reg || adv;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (accept) begin
            in_valid_reg <= 1'b1;
        end else if (adv) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            canon_reg <= s_canonical_index;
            first_reg <= s_first_of_run;
        end
    end

    // Run state as seen by the current transaction; a first item starts from a clean run.
    assign pr_eff     = first_reg ? '0 : physical_row_reg;
    assign failed_eff = first_reg ? 1'b0 : run_failed_reg;

    // Limits: the count saturates at the bitmap size and the width at its maximum.
    assign count_ext = CMP_W'(count_reg);
    assign count_cl  = (count_ext > CMP_W'(MAX_ROWS)) ? CMP_W'(MAX_ROWS) : count_ext;
    assign width_cl  = (width_reg > RWIDTH_W'(WIDTH_LIMIT)) ? RWIDTH_W'(WIDTH_LIMIT) : width_reg;

    assign permute   = (mode_reg == MODE_PACK) || (mode_reg == MODE_UNPACK);
    assign canon_bad = (CMP_W'(canon_reg) >= count_cl) || mark_seen;
    assign pr_plus   = CMP_W'(pr_eff) + CMP_W'(1);
    assign done      = pr_plus >= count_cl;

    // Classify the transaction and pick the source and destination rows.
    always_comb begin
        status     = ST_COPY;
        last       = 1'b0;
        src_row    = '0;
        dst_row    = '0;
        set_mark   = 1'b0;
        fail_set   = 1'b0;
        done_clear = 1'b0;
        if (failed_eff) begin
            status = ST_SKIPPED;
        end else if ((count_reg == '0) || (width_reg == '0)) begin
            status   = ST_INVALID;
            last     = 1'b1;
            fail_set = 1'b1;
        end else if (permute && canon_bad) begin
            status   = ST_INVALID;
            last     = 1'b1;
            fail_set = 1'b1;
        end else begin
            set_mark   = permute;
            last       = done;
            done_clear = done;
            if (mode_reg == MODE_PACK) begin
                src_row = canon_reg;
                dst_row = CANON_W'(pr_eff);
            end else if (mode_reg == MODE_UNPACK) begin
                src_row = CANON_W'(pr_eff);
                dst_row = canon_reg;
            end else begin
                src_row = CANON_W'(pr_eff);
                dst_row = CANON_W'(pr_eff);
            end
        end
    end

    // Row counter and failure flag.
    always_comb begin
        run_failed_next = failed_eff || fail_set;
        if (done_clear) begin
            physical_row_next = '0;
        end else if (status == ST_COPY) begin
            physical_row_next = pr_plus[PR_W-1:0];
        end else begin
            physical_row_next = pr_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            physical_row_reg <= '0;
            run_failed_reg   <= 1'b0;
        end else if (adv) begin
            physical_row_reg <= physical_row_next;
            run_failed_reg   <= run_failed_next;
        end
    end

    assign mark_upd = '{apply: adv, first: first_reg, set_mark: set_mark, clear_all: done_clear};

    ppua_mark_store #(
        .MAX_ROWS(MAX_ROWS)
    ) u_mark_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (accept),
        .rd_index  (s_canonical_index),
        .cur_index (canon_reg),
        .upd       (mark_upd),
        .mark_seen (mark_seen)
    );

    ppua_offset_unit u_offset_unit (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .load                 (adv),
        .src_row              (src_row),
        .dst_row              (dst_row),
        .row_width            (width_cl),
        .status               (status),
        .last                 (last),
        .m_ready              (m_ready),
        .m_valid              (m_valid),
        .m_source_offset      (m_source_offset),
        .m_destination_offset (m_destination_offset),
        .m_status             (m_status),
        .m_last               (m_last)
    );

    // Checks on the run control and the result encoding.
`include "permutation_pack_unpack_addresser_assert.svh"

    `PPUA_ASSERT(a_err_zero_offs, aclk, aresetn, m_valid && (m_status != ST_COPY), (m_source_offset == '0) && (m_destination_offset == '0))
    `PPUA_ASSERT_NEXT(a_row_wraps, aclk, aresetn, adv && done_clear, physical_row_reg == '0)
    `PPUA_ASSERT_NEXT(a_fail_sticky, aclk, aresetn, adv && run_failed_reg && !first_reg, run_failed_reg)
    `PPUA_ASSERT(a_mark_mode, aclk, aresetn, mark_upd.apply && mark_upd.set_mark, (mode_reg == MODE_PACK) || (mode_reg == MODE_UNPACK))

endmodule
